### rtl/bounded_array_deque_macros.svh
// ----------------------------------------------------------------------------
// Bounded array deque assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_DEQUE_MACROS_SVH
`define BOUNDED_ARRAY_DEQUE_MACROS_SVH

// same-cycle implication
`define BAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bad_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array deque package
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package bad_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ      = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // broadcast to every cell
  typedef struct packed {
    logic shift_in;     // insert at front: every key moves one cell back
    logic shift_out;    // remove first: every key moves one cell forward
    logic write_end;    // insert at end: the selected cell takes the key
    logic load_probe;   // copy keys into the probe chain
    logic shift_probe;  // probe chain moves one cell toward cell 0
  } cell_ctrl_t;

endpackage

### rtl/bad_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// Holds one key and one probe word; trades keys with its neighbors.
// ----------------------------------------------------------------------------
module bad_cell (
  input  logic                            clk,
  input  bad_pkg::cell_ctrl_t             ctrl,
  input  logic                            sel,
  input  logic signed [bad_pkg::KEY_W-1:0] new_key,
  input  logic signed [bad_pkg::KEY_W-1:0] prev_key,
  input  logic signed [bad_pkg::KEY_W-1:0] next_key,
  input  logic signed [bad_pkg::KEY_W-1:0] next_probe,
  output logic signed [bad_pkg::KEY_W-1:0] key,
  output logic signed [bad_pkg::KEY_W-1:0] probe
);

  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      key <= prev_key;
    end else if (ctrl.shift_out) begin
      key <= next_key;
    end else if (ctrl.write_end && sel) begin
      key <= new_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_probe) begin
      probe <= key;
    end else if (ctrl.shift_probe) begin
      probe <= next_probe;
    end
  end

endmodule

### rtl/bad_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Decodes commands, keeps the key count, steers the cells, registers results.
// ----------------------------------------------------------------------------
module bad_ctrl #(
  parameter int CAPACITY = bad_pkg::CAPACITY_DEFAULT,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [bad_pkg::OP_W-1:0]           operation,
  input  logic [bad_pkg::POS_W-1:0]          position,
  input  logic signed [bad_pkg::KEY_W-1:0]   probe_head,
  output logic                               busy,
  output bad_pkg::cell_ctrl_t                cell_ctrl,
  output logic [CW-1:0]                      count,
  output logic                               done,
  output logic [bad_pkg::STATUS_W-1:0]       status,
  output logic signed [bad_pkg::KEY_W-1:0]   read_key,
  output logic [bad_pkg::COUNT_W-1:0]        entry_count
);

  localparam int CMPW = (CW > bad_pkg::POS_W) ? CW : bad_pkg::POS_W;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PROBE = 2'b10
  } state_t;

  state_t                             state, state_next;
  logic [CW-1:0]                      count_next;
  logic [bad_pkg::POS_W-1:0]          remaining, remaining_next;
  logic                               done_next;
  logic [bad_pkg::STATUS_W-1:0]       status_next;
  logic signed [bad_pkg::KEY_W-1:0]   read_key_next;
  logic                               full, empty, in_range;

  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign in_range = (CMPW'(position) < CMPW'(count));
  assign busy     = (state == ST_PROBE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    done_next      = 1'b0;
    status_next    = status;
    read_key_next  = read_key;
    cell_ctrl      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          done_next     = 1'b1;
          status_next   = bad_pkg::ST_OK;
          read_key_next = '0;
          unique case (operation)
            bad_pkg::OP_INS_FRONT: begin
              if (full) begin
                status_next = bad_pkg::ST_FULL;
              end else begin
                cell_ctrl.shift_in = 1'b1;
                count_next         = count + 1'b1;
              end
            end
            bad_pkg::OP_INS_END: begin
              if (full) begin
                status_next = bad_pkg::ST_FULL;
              end else begin
                cell_ctrl.write_end = 1'b1;
                count_next          = count + 1'b1;
              end
            end
            bad_pkg::OP_READ: begin
              if (in_range) begin
                done_next            = 1'b0;
                cell_ctrl.load_probe = 1'b1;
                remaining_next       = position;
                state_next           = ST_PROBE;
              end else begin
                status_next = bad_pkg::ST_EMPTY;
              end
            end
            bad_pkg::OP_DEL_FIRST: begin
              if (empty) begin
                status_next = bad_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.shift_out = 1'b1;
                count_next          = count - 1'b1;
              end
            end
            bad_pkg::OP_DEL_LAST: begin
              if (empty) begin
                status_next = bad_pkg::ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (remaining == '0) begin
          done_next     = 1'b1;
          status_next   = bad_pkg::ST_OK;
          read_key_next = probe_head;
          state_next    = ST_IDLE;
        end else begin
          cell_ctrl.shift_probe = 1'b1;
          remaining_next        = remaining - 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining   <= remaining_next;
    status      <= status_next;
    read_key    <= read_key_next;
    entry_count <= bad_pkg::COUNT_W'(count_next);
  end

endmodule

### rtl/bounded_array_deque.sv
// ----------------------------------------------------------------------------
// Bounded array deque
// Ordered list of up to CAPACITY signed keys held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command (operation, new_key, position) transfers on a clock edge with
//   start high and busy low. Each command yields one result (status,
//   read_key, entry_count), shown for one cycle with done high.
//   Inserts, removals, rejected commands and unused codes: result in the cycle
//   after the command; busy stays low, so a command may enter every cycle.
//   Read at position p within the list: the keys are copied into a probe
//   chain that moves one cell toward the head each cycle, so the result
//   comes once key p has reached the head; busy is high until the result.
//   Front insert and first removal move every key one cell at once; the
//   end insert writes the cell at the current count.
//   Reset empties the list; done is low after reset. Results cannot be held
//   off: a result is gone after its one cycle.
// ----------------------------------------------------------------------------
module bounded_array_deque #(
  parameter int CAPACITY = bad_pkg::CAPACITY_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bad_pkg::OP_W-1:0]           operation,
  input  logic signed [bad_pkg::KEY_W-1:0]   new_key,
  input  logic [bad_pkg::POS_W-1:0]          position,
  output logic                               done,
  output logic [bad_pkg::STATUS_W-1:0]       status,
  output logic signed [bad_pkg::KEY_W-1:0]   read_key,
  output logic [bad_pkg::COUNT_W-1:0]        entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  bad_pkg::cell_ctrl_t              cell_ctrl;
  logic [CW-1:0]                    count;
  logic signed [bad_pkg::KEY_W-1:0] keys   [CAPACITY];
  logic signed [bad_pkg::KEY_W-1:0] probes [CAPACITY];

  bad_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .position    (position),
    .probe_head  (probes[0]),
    .busy        (busy),
    .cell_ctrl   (cell_ctrl),
    .count       (count),
    .done        (done),
    .status      (status),
    .read_key    (read_key),
    .entry_count (entry_count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [bad_pkg::KEY_W-1:0] prev_key, next_key, next_probe;
    logic                             sel;

    assign sel = (count == CW'(i));

    if (i == 0) begin : g_head
      assign prev_key = new_key;
    end else begin : g_body
      assign prev_key = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key   = keys[i];
      assign next_probe = probes[i];
    end else begin : g_link
      assign next_key   = keys[i+1];
      assign next_probe = probes[i+1];
    end

    bad_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .sel        (sel),
      .new_key    (new_key),
      .prev_key   (prev_key),
      .next_key   (next_key),
      .next_probe (next_probe),
      .key        (keys[i]),
      .probe      (probes[i])
    );
  end

endmodule

### rtl/bad_checker.sv
// ----------------------------------------------------------------------------
// Bounded array deque checker
// Port-level checks on command acceptance, result timing and result contents.
// ----------------------------------------------------------------------------
`include "bounded_array_deque_macros.svh"

module bad_checker #(
  parameter int CAPACITY = bad_pkg::CAPACITY_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [bad_pkg::OP_W-1:0]           operation,
  input logic                               done,
  input logic [bad_pkg::STATUS_W-1:0]       status,
  input logic signed [bad_pkg::KEY_W-1:0]   read_key,
  input logic [bad_pkg::COUNT_W-1:0]        entry_count
);

  logic cmd_xfer;
  logic rd_xfer;

  assign cmd_xfer = start && !busy;
  assign rd_xfer  = cmd_xfer && (operation == bad_pkg::OP_READ);

  `BAD_ASSERT_NOW(a_done_not_busy, done, !busy, "result while busy")
  `BAD_ASSERT_NEXT(a_quick_result, cmd_xfer && !rd_xfer, done, "missing result")
  `BAD_ASSERT_NEXT(a_read_progress, rd_xfer, busy || done, "read stalled")
  `BAD_ASSERT_NOW(a_fail_no_key, done && (status != bad_pkg::ST_OK), read_key == '0,
                  "key on failed result")
  `BAD_ASSERT_NOW(a_full_count, done && (status == bad_pkg::ST_FULL),
                  entry_count == bad_pkg::COUNT_W'(CAPACITY), "full with room left")

endmodule

bind bounded_array_deque bad_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
